FILE: rtl/core/srl_pkg.sv
// Package for the sequential record list: sizes, command, status and
// sequencer state codes. No dependencies.
`timescale 1ns / 1ps

package srl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 48;
  localparam int REC_W    = KEY_W + PAY_W;

  typedef enum logic [3:0] {
    CMD_INS_FRONT = 4'd0,
    CMD_INS_END   = 4'd1,
    CMD_INS_ORD   = 4'd2,
    CMD_DEL_SHIFT = 4'd3,
    CMD_DEL_SWAP  = 4'd4,
    CMD_DEL_FIRST = 4'd5,
    CMD_DEL_LAST  = 4'd6,
    CMD_GET_POS   = 4'd7,
    CMD_GET_KEY   = 4'd8,
    CMD_QUERY     = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_OPEN,
    S_CLOSE,
    S_FETCH,
    S_FWAIT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/srl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sequential_record_list_unit.sv
// Top level of the sequential record list: command sequencer around one
// record RAM (key and payload per entry). Depends on srl_pkg and srl_ram.
`timescale 1ns / 1ps

// One item at a time: a new command is taken only in the idle state. Query
// and full, empty or bad position results go from decode straight to the
// result state; insert at end or into an empty list adds one RAM write, and
// lookup by position and remove last one RAM read. A key search walks the RAM,
// one entry per cycle, for get key, swap remove, shifting remove and ordered
// insert. Front insert, remove first and shifting remove move the entries one
// place each, and an ordered insert opens a gap after its search. The single
// RAM read port sets the pace of these steps. The next item is taken while the
// previous result still waits at the output.

module sequential_record_list_unit
  import srl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              in_command,
  input  logic signed [KEY_W-1:0] in_entry_key,
  input  logic [PAY_W-1:0]        in_entry_payload,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_status,
  output logic signed [KEY_W-1:0] out_found_key,
  output logic [PAY_W-1:0]        out_found_payload,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_is_full,
  output logic                    out_is_empty
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ra_r, ra_nxt;
  logic [IDX_W-1:0]  di_r, di_nxt;
  logic              dv_r, dv_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic              stop_r, stop_nxt;
  logic              inc_r, inc_nxt;
  logic              dec_r, dec_nxt;
  status_t           status_r, status_nxt;
  logic [KEY_W-1:0]  fkey_r, fkey_nxt;
  logic [PAY_W-1:0]  fpay_r, fpay_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [PAY_W-1:0]  out_pay_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [REC_W-1:0]  wdata;
  logic [REC_W-1:0]  rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [PAY_W-1:0]  rd_pay;

  logic              is_full_now, is_empty_now, bad_pos;
  logic              scan_match, scan_hit, scan_miss, di_last;
  logic              issue_up, open_done, close_done, out_free;
  logic [CNT_W-1:0]  last_cnt, new_count;

  srl_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rd_key       = rdata[REC_W-1 -: KEY_W];
  assign rd_pay       = rdata[PAY_W-1:0];
  assign is_full_now  = (count_r == CNT_W'(CAPACITY));
  assign is_empty_now = (count_r == '0);
  assign bad_pos      = (pos_r == '0) || (CMP_W'(pos_r) > CMP_W'(count_r));
  assign last_cnt     = count_r - 1'b1;
  assign di_last      = (CNT_W'(di_r) == last_cnt);
  assign scan_match   = (cmd_r == CMD_INS_ORD) ? !($signed(rd_key) < $signed(key_r))
                                               : (rd_key == key_r);
  assign scan_hit     = dv_r && scan_match;
  assign scan_miss    = dv_r && !scan_match && di_last;
  assign issue_up     = (ra_r < count_r);
  assign open_done    = stop_r && !dv_r;
  assign close_done   = !issue_up && !dv_r;
  assign out_free     = !out_valid_r || !out_stall;
  assign new_count    = count_r + CNT_W'(inc_r) - CNT_W'(dec_r);
  assign in_stall     = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_r)
          CMD_INS_FRONT: state_nxt = is_full_now ? S_DONE :
                                     (is_empty_now ? S_WRITE : S_OPEN);
          CMD_INS_END:   state_nxt = is_full_now ? S_DONE : S_WRITE;
          CMD_INS_ORD:   state_nxt = is_full_now ? S_DONE :
                                     (is_empty_now ? S_WRITE : S_SCAN);
          CMD_DEL_SHIFT, CMD_DEL_SWAP, CMD_GET_KEY:
                         state_nxt = is_empty_now ? S_DONE : S_SCAN;
          CMD_DEL_FIRST, CMD_DEL_LAST:
                         state_nxt = is_empty_now ? S_DONE : S_FETCH;
          CMD_GET_POS:   state_nxt = bad_pos ? S_DONE : S_FETCH;
          default:       state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (scan_hit) begin
          case (cmd_r)
            CMD_INS_ORD:   state_nxt = S_OPEN;
            CMD_DEL_SHIFT: state_nxt = S_CLOSE;
            CMD_DEL_SWAP:  state_nxt = S_FETCH;
            default:       state_nxt = S_DONE;
          endcase
        end else if (scan_miss) begin
          state_nxt = (cmd_r == CMD_INS_ORD) ? S_WRITE : S_DONE;
        end
      end
      S_OPEN:  if (open_done) state_nxt = S_WRITE;
      S_CLOSE: if (close_done) state_nxt = S_DONE;
      S_FETCH: state_nxt = S_FWAIT;
      S_FWAIT: state_nxt = (cmd_r == CMD_DEL_FIRST) ? S_CLOSE : S_DONE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    pay_nxt    = pay_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    ra_nxt     = ra_r;
    di_nxt     = di_r;
    dv_nxt     = 1'b0;
    tgt_nxt    = tgt_r;
    stop_nxt   = stop_r;
    inc_nxt    = inc_r;
    dec_nxt    = dec_r;
    status_nxt = status_r;
    fkey_nxt   = fkey_r;
    fpay_nxt   = fpay_r;
    we         = 1'b0;
    waddr      = tgt_r;
    wdata      = {key_r, pay_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = cmd_t'(in_command);
          key_nxt = in_entry_key;
          pay_nxt = in_entry_payload;
          pos_nxt = in_position;
        end
      end
      S_DECODE: begin
        status_nxt = ST_OK;
        fkey_nxt   = '0;
        fpay_nxt   = '0;
        inc_nxt    = 1'b0;
        dec_nxt    = 1'b0;
        stop_nxt   = 1'b0;
        tgt_nxt    = '0;
        ra_nxt     = '0;
        case (cmd_r)
          CMD_INS_FRONT, CMD_INS_END, CMD_INS_ORD: begin
            if (is_full_now) begin
              status_nxt = ST_FULL;
            end else begin
              inc_nxt = 1'b1;
              if (cmd_r == CMD_INS_FRONT) ra_nxt = last_cnt;
              if (cmd_r == CMD_INS_END) tgt_nxt = count_r[IDX_W-1:0];
            end
          end
          CMD_DEL_SHIFT, CMD_DEL_SWAP, CMD_GET_KEY: begin
            if (is_empty_now) status_nxt = ST_EMPTY;
          end
          CMD_DEL_FIRST, CMD_DEL_LAST: begin
            if (is_empty_now) begin
              status_nxt = ST_EMPTY;
            end else begin
              dec_nxt = 1'b1;
              if (cmd_r == CMD_DEL_LAST) ra_nxt = last_cnt;
            end
          end
          CMD_GET_POS: begin
            if (bad_pos) status_nxt = ST_BADPOS;
            else ra_nxt = CNT_W'(pos_r) - 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        ra_nxt = ra_r + 1'b1;
        di_nxt = ra_r[IDX_W-1:0];
        dv_nxt = issue_up && !scan_hit && !scan_miss;
        if (scan_hit) begin
          tgt_nxt = di_r;
          if (cmd_r != CMD_INS_ORD) begin
            fkey_nxt = rd_key;
            fpay_nxt = rd_pay;
          end
          case (cmd_r)
            CMD_INS_ORD: ra_nxt = last_cnt;
            CMD_DEL_SHIFT: begin
              dec_nxt = 1'b1;
              ra_nxt  = CNT_W'(di_r) + 1'b1;
            end
            CMD_DEL_SWAP: begin
              dec_nxt = 1'b1;
              ra_nxt  = last_cnt;
            end
            default: ;
          endcase
        end else if (scan_miss) begin
          if (cmd_r == CMD_INS_ORD) tgt_nxt = count_r[IDX_W-1:0];
          else status_nxt = ST_NOTFOUND;
        end
      end
      S_OPEN: begin
        dv_nxt = !stop_r;
        di_nxt = ra_r[IDX_W-1:0];
        ra_nxt = ra_r - 1'b1;
        if (!stop_r && (ra_r == CNT_W'(tgt_r))) stop_nxt = 1'b1;
        we    = dv_r;
        waddr = di_r + 1'b1;
        wdata = rdata;
      end
      S_CLOSE: begin
        dv_nxt = issue_up;
        di_nxt = ra_r[IDX_W-1:0];
        ra_nxt = ra_r + 1'b1;
        we     = dv_r;
        waddr  = di_r - 1'b1;
        wdata  = rdata;
      end
      S_FWAIT: begin
        if (cmd_r == CMD_DEL_SWAP) begin
          we    = 1'b1;
          wdata = rdata;
        end else begin
          fkey_nxt = rd_key;
          fpay_nxt = rd_pay;
        end
        if (cmd_r == CMD_DEL_FIRST) begin
          ra_nxt  = CNT_W'(1);
          tgt_nxt = '0;
        end
      end
      S_WRITE: we = 1'b1;
      S_DONE: begin
        if (out_free) count_nxt = new_count;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((state_r == S_DONE) && out_free) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    pos_r    <= pos_nxt;
    ra_r     <= ra_nxt;
    di_r     <= di_nxt;
    tgt_r    <= tgt_nxt;
    stop_r   <= stop_nxt;
    inc_r    <= inc_nxt;
    dec_r    <= dec_nxt;
    status_r <= status_nxt;
    fkey_r   <= fkey_nxt;
    fpay_r   <= fpay_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_key_r    <= fkey_r;
      out_pay_r    <= fpay_r;
      out_count_r  <= new_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_key     = out_key_r;
  assign out_found_payload = out_pay_r;
  assign out_entry_count   = out_count_r;
  assign out_is_full       = (out_count_r == CNT_W'(CAPACITY));
  assign out_is_empty      = (out_count_r == '0);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_count_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(state_r) == S_DONE)
    else $error("record count changed outside result delivery");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DECODE || state_r == S_DONE) |-> !we)
    else $error("RAM write outside a list update");

endmodule

FILE: sim/sequential_record_list_unit_tb.sv
// Testbench for sequential_record_list_unit: directed and random list commands,
// results checked against a behavioral list model in a scoreboard class.
// Depends on srl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module sequential_record_list_unit_tb;
  import srl_pkg::*;

  typedef struct packed {
    logic [2:0]        status;
    logic [KEY_W-1:0]  fkey;
    logic [PAY_W-1:0]  fpay;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              empty;
  } list_result_t;

  class list_scoreboard;
    logic [KEY_W-1:0] keys[$];
    logic [PAY_W-1:0] pays[$];
    list_result_t     pending[$];
    int               errors;

    function void note_command(logic [3:0] cmd, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos);
      list_result_t r;
      int i;
      r = '0;
      case (cmd)
        CMD_INS_FRONT, CMD_INS_END, CMD_INS_ORD: begin
          if (keys.size() >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            if (cmd == CMD_INS_FRONT) i = 0;
            else if (cmd == CMD_INS_END) i = keys.size();
            else begin
              i = 0;
              while (i < keys.size() && $signed(keys[i]) < $signed(key)) i++;
            end
            keys.insert(i, key);
            pays.insert(i, pay);
          end
        end
        CMD_DEL_SHIFT, CMD_DEL_SWAP, CMD_GET_KEY: begin
          if (keys.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            i = 0;
            while (i < keys.size() && keys[i] != key) i++;
            if (i >= keys.size()) begin
              r.status = ST_NOTFOUND;
            end else begin
              r.fkey = keys[i];
              r.fpay = pays[i];
              if (cmd == CMD_DEL_SHIFT) begin
                keys.delete(i);
                pays.delete(i);
              end else if (cmd == CMD_DEL_SWAP) begin
                keys[i] = keys[keys.size()-1];
                pays[i] = pays[pays.size()-1];
                void'(keys.pop_back());
                void'(pays.pop_back());
              end
            end
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST: begin
          if (keys.size() == 0) begin
            r.status = ST_EMPTY;
          end else if (cmd == CMD_DEL_FIRST) begin
            r.fkey = keys.pop_front();
            r.fpay = pays.pop_front();
          end else begin
            r.fkey = keys.pop_back();
            r.fpay = pays.pop_back();
          end
        end
        CMD_GET_POS: begin
          if (pos == 0 || pos > keys.size()) begin
            r.status = ST_BADPOS;
          end else begin
            r.fkey = keys[pos-1];
            r.fpay = pays[pos-1];
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(keys.size());
      r.full  = (keys.size() >= CAPACITY);
      r.empty = (keys.size() == 0);
      pending.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.fkey !== exp.fkey) begin
        $display("%0t: found_key exp %h got %h", $time, exp.fkey, got.fkey);
        errors++;
      end
      if (got.fpay !== exp.fpay) begin
        $display("%0t: found_payload exp %h got %h", $time, exp.fpay, got.fpay);
        errors++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: entry_count exp %0d got %0d", $time, exp.count, got.count);
        errors++;
      end
      if (got.full !== exp.full) begin
        $display("%0t: is_full exp %b got %b", $time, exp.full, got.full);
        errors++;
      end
      if (got.empty !== exp.empty) begin
        $display("%0t: is_empty exp %b got %b", $time, exp.empty, got.empty);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_command = '0;
  logic signed [KEY_W-1:0] in_entry_key = '0;
  logic [PAY_W-1:0] in_entry_payload = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic signed [KEY_W-1:0] out_found_key;
  logic [PAY_W-1:0] out_found_payload;
  logic [CNT_W-1:0] out_entry_count;
  logic out_is_full;
  logic out_is_empty;

  list_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  logic [KEY_W-1:0] used_keys[$];

  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  sequential_record_list_unit dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({out_status, out_found_key, out_found_payload,
                         out_entry_count, out_is_full, out_is_empty});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  task automatic send_command(logic [3:0] cmd, logic [KEY_W-1:0] key,
                              logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos);
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_entry_key     <= key;
    in_entry_payload <= pay;
    in_position      <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(cmd, key, pay, pos);
    if (cmd <= CMD_INS_ORD) used_keys.push_back(key);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && used_keys.size() > 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r < 8) return $urandom_range(0, 15) - 8;
    return $urandom;
  endfunction

  initial begin
    int n, burst, r, fill_bias, next_flip;
    logic [3:0] cmd;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list cases, extremes, every command
    send_command(CMD_DEL_SHIFT, 32'sd5, '0, 7'd1);
    send_command(CMD_DEL_SWAP, 32'sd5, '0, 7'd1);
    send_command(CMD_DEL_FIRST, '0, '0, 7'd1);
    send_command(CMD_DEL_LAST, '0, '0, 7'd1);
    send_command(CMD_GET_KEY, '0, '0, 7'd1);
    send_command(CMD_GET_POS, '0, '0, 7'd1);
    send_command(CMD_INS_END, 32'h7fffffff, '1, 7'd0);
    send_command(CMD_INS_FRONT, 32'h80000000, 48'h0, 7'h7f);
    send_command(CMD_INS_ORD, 32'sd0, 48'h123456789abc, 7'd0);
    send_command(CMD_INS_ORD, 32'sd0, 48'h555555555555, 7'd0);
    send_command(CMD_INS_ORD, -32'sd1, 48'haaaaaaaaaaaa, 7'd0);
    send_command(CMD_GET_POS, '0, '0, 7'd0);
    send_command(CMD_GET_POS, '0, '0, 7'd5);
    send_command(CMD_GET_POS, '0, '0, 7'd6);
    send_command(CMD_GET_POS, '0, '0, 7'h7f);
    send_command(CMD_GET_KEY, 32'sd0, '0, 7'd0);
    send_command(CMD_GET_KEY, 32'sd77, '0, 7'd0);
    send_command(CMD_DEL_SWAP, 32'h80000000, '0, 7'd0);
    send_command(CMD_DEL_SHIFT, 32'sd0, '0, 7'd0);
    send_command(CMD_DEL_SHIFT, 32'sd99, '0, 7'd0);
    send_command(CMD_QUERY, '0, '0, 7'd0);
    send_command(4'd15, '1, '1, 7'h7f);
    send_command(4'd10, '0, '0, 7'd0);
    send_command(CMD_DEL_FIRST, '0, '0, 7'd0);
    send_command(CMD_DEL_LAST, '0, '0, 7'd0);

    // random: phases that lean toward filling or draining the list
    n = 0;
    fill_bias = 25;
    next_flip = 0;
    while (n < 1200) begin
      if (n >= next_flip) begin
        fill_bias = (fill_bias > 50) ? 25 : 85;
        next_flip = n + 150;
      end
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < fill_bias) cmd = 4'($urandom_range(CMD_INS_FRONT, CMD_INS_ORD));
        else if (r < 95) cmd = 4'($urandom_range(CMD_DEL_SHIFT, CMD_QUERY));
        else cmd = 4'($urandom_range(10, 15));
        send_command(cmd, pick_key(), PAY_W'({$urandom, $urandom}),
                     ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                 : 7'($urandom_range(0, 66)));
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
